### rtl/lbvs_pkg.sv
// Shared types and constants for the linear blend vertex skinning block.
package lbvs_pkg;

  localparam int unsigned MaxBones   = 128;
  localparam int unsigned Influences = 4;
  localparam int unsigned IdW        = 7;
  localparam int unsigned WtW        = 16;
  localparam int unsigned MemDepth   = MaxBones * 16;
  localparam int unsigned MemAw      = $clog2(MemDepth);
  localparam int unsigned InflW      = $clog2(Influences);
  localparam int unsigned QDepth     = 2;
  localparam int unsigned AccW       = 72;
  localparam logic signed [31:0] OneQ16 = 32'sd65536;

  typedef struct packed {
    logic               kind;
    logic [6:0]         bone_slot;
    logic [3:0]         matrix_element;
    logic signed [31:0] matrix_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic signed [31:0] norm_z;
    logic [27:0]        bone_ids;
    logic [63:0]        bone_weights;
  } req_in_t;

  typedef struct packed {
    logic signed [31:0] skinned_x;
    logic signed [31:0] skinned_y;
    logic signed [31:0] skinned_z;
    logic signed [31:0] skinned_w;
    logic signed [31:0] line_end_x;
    logic signed [31:0] line_end_y;
    logic signed [31:0] line_end_z;
  } req_out_t;

  // Classified vertex job passed from front to back.
  typedef struct packed {
    logic signed [31:0] px, py, pz, nx, ny, nz;
    logic [Influences-1:0]          use_mask;
    logic [Influences-1:0][IdW-1:0] ids;
    logic [Influences-1:0][WtW-1:0] wts;
  } job_t;

  function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] v);
    if (v > AccW'(64'sh7fffffff))       return 32'sh7fffffff;
    else if (v < -AccW'(64'sh80000000)) return 32'sh80000000;
    else                                return v[31:0];
  endfunction

endpackage

### rtl/lbvs_front.sv
// Front end: accepts requests, writes the bone table, queues vertex jobs.
module lbvs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lbvs_pkg::req_in_t   in_data_i,
  input  logic                back_busy_i,
  output logic                mem_we_o,
  output logic [lbvs_pkg::MemAw-1:0] mem_waddr_o,
  output logic signed [31:0]  mem_wdata_o,
  output logic                job_valid_o,
  input  logic                job_pop_i,
  output lbvs_pkg::job_t      job_o
);
  import lbvs_pkg::*;

  job_t                 q_mem [QDepth];
  logic                 wp_q, wp_d, rp_q, rp_d;
  logic [1:0]           cnt_q, cnt_d;
  logic                 acc, push;
  job_t                 job;

  // vertices stall on a full queue; writes wait until queued and running
  // vertices have fetched all their rows
  assign in_stall_o = in_data_i.kind ? (cnt_q == 2'(QDepth))
                                     : ((cnt_q != '0) || back_busy_i);
  assign acc  = in_valid_i && !in_stall_o;
  assign push = acc && in_data_i.kind;

  assign mem_we_o    = acc && !in_data_i.kind && (32'(in_data_i.bone_slot) < MaxBones);
  assign mem_waddr_o = MemAw'({in_data_i.bone_slot, in_data_i.matrix_element});
  assign mem_wdata_o = in_data_i.matrix_value;

  always_comb begin
    job.px = in_data_i.pos_x; job.py = in_data_i.pos_y; job.pz = in_data_i.pos_z;
    job.nx = in_data_i.norm_x; job.ny = in_data_i.norm_y; job.nz = in_data_i.norm_z;
    for (int i = 0; i < Influences; i++) begin
      job.ids[i] = in_data_i.bone_ids[i*IdW +: IdW];
      job.wts[i] = in_data_i.bone_weights[i*WtW +: WtW];
      // skip non-positive weights and ids past the table
      job.use_mask[i] = !job.wts[i][WtW-1] && (job.wts[i] != '0)
                        && (32'(job.ids[i]) < MaxBones);
    end
  end

  assign wp_d  = push ? ~wp_q : wp_q;
  assign rp_d  = job_pop_i ? ~rp_q : rp_q;
  assign cnt_d = cnt_q + 2'(push) - 2'(job_pop_i);
  assign job_valid_o = cnt_q != '0;
  assign job_o = q_mem[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= job;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      wp_q <= wp_d; rp_q <= rp_d; cnt_q <= cnt_d;
    end
  end
endmodule

### rtl/lbvs_back.sv
// Back end: bone table memory and the per-influence blend pipeline.
module lbvs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                mem_we_i,
  input  logic [lbvs_pkg::MemAw-1:0] mem_waddr_i,
  input  logic signed [31:0]  mem_wdata_i,
  input  logic                job_valid_i,
  output logic                job_pop_o,
  input  lbvs_pkg::job_t      job_i,
  output logic                busy_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lbvs_pkg::req_out_t  out_data_o
);
  import lbvs_pkg::*;

  // Bone table: 128 bones x 4 rows of 4 elements, one row read per cycle while the output is not held.
  logic [127:0] mem [MaxBones*4];
  logic [3:0][31:0] row_q;
  logic [IdW+1:0] raddr;

  // Issue stage: walks 4 influences x 4 rows per vertex.
  logic            busy_q, busy_d;
  logic [InflW-1:0] inf_q, inf_d;
  logic [1:0]      row_q_i, row_d_i;
  job_t            job_q;
  logic            issue, adv, fin;

  // s1 after the row read, s2 products, s3 row sums, s4 weighted terms.
  logic s1_v_q, s1_last_q, s1_use_q; logic [1:0] s1_row_q; logic signed [15:0] s1_w_q;
  logic s2_v_q, s2_last_q, s2_use_q; logic [1:0] s2_row_q; logic signed [15:0] s2_w_q;
  logic s3_v_q, s3_last_q, s3_use_q; logic [1:0] s3_row_q; logic signed [15:0] s3_w_q;
  logic s4_v_q, s4_last_q, s4_use_q; logic [1:0] s4_row_q;
  logic signed [63:0] prod_p_q [4];
  logic signed [63:0] prod_n_q [3];
  logic signed [49:0] sp_q, sn_q;
  logic signed [65:0] wp_q, wn_q;
  logic signed [AccW-1:0] accp_q [4];
  logic signed [AccW-1:0] accn_q [3];
  logic signed [AccW-1:0] fw;
  logic signed [31:0] bpx_q, bpy_q, bpz_q, bnx_q, bny_q, bnz_q;
  logic  o_v_q;
  req_out_t o_q;

  // any final-stage completion must find output free; hold everything otherwise
  assign adv = !(o_v_q && out_stall_i);

  assign issue    = busy_q && adv;
  assign job_pop_o = !busy_q && job_valid_i;
  assign raddr    = {job_q.ids[inf_q], row_q_i};
  assign busy_o   = busy_q;

  always_comb begin
    busy_d = busy_q; inf_d = inf_q; row_d_i = row_q_i;
    if (job_pop_o) begin
      busy_d = 1'b1; inf_d = '0; row_d_i = '0;
    end else if (issue) begin
      row_d_i = row_q_i + 2'd1;
      if (row_q_i == 2'd3) begin
        inf_d = inf_q + 1'b1;
        if (inf_q == InflW'(Influences-1)) busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we_i) mem[mem_waddr_i[MemAw-1:2]][mem_waddr_i[1:0]*32 +: 32] <= mem_wdata_i;
    if (issue) row_q <= mem[raddr];
    if (job_pop_o) job_q <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; inf_q <= '0; row_q_i <= '0;
    end else begin
      busy_q <= busy_d; inf_q <= inf_d; row_q_i <= row_d_i;
    end
  end

  // Payload pipeline; control bits reset below.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (issue) begin
        s1_row_q <= row_q_i; s1_use_q <= job_q.use_mask[inf_q];
        s1_w_q <= job_q.wts[inf_q];
        s1_last_q <= (row_q_i == 2'd3) && (inf_q == InflW'(Influences-1));
        bpx_q <= job_q.px; bpy_q <= job_q.py; bpz_q <= job_q.pz;
        bnx_q <= job_q.nx; bny_q <= job_q.ny; bnz_q <= job_q.nz;
      end
      // products, row elements times (pos,1) and normal
      prod_p_q[0] <= $signed(row_q[0]) * bpx_q;
      prod_p_q[1] <= $signed(row_q[1]) * bpy_q;
      prod_p_q[2] <= $signed(row_q[2]) * bpz_q;
      prod_p_q[3] <= $signed(row_q[3]) * OneQ16;
      prod_n_q[0] <= $signed(row_q[0]) * bnx_q;
      prod_n_q[1] <= $signed(row_q[1]) * bny_q;
      prod_n_q[2] <= $signed(row_q[2]) * bnz_q;
      s2_row_q <= s1_row_q; s2_use_q <= s1_use_q; s2_w_q <= s1_w_q; s2_last_q <= s1_last_q;
      // floor shifts, exact row sums (each term fits 48 bits)
      sp_q <= 50'(prod_p_q[0] >>> 16) + 50'(prod_p_q[1] >>> 16)
            + 50'(prod_p_q[2] >>> 16) + 50'(prod_p_q[3] >>> 16);
      sn_q <= 50'(prod_n_q[0] >>> 16) + 50'(prod_n_q[1] >>> 16)
            + 50'(prod_n_q[2] >>> 16);
      s3_row_q <= s2_row_q; s3_use_q <= s2_use_q; s3_last_q <= s2_last_q;
      s3_w_q <= s2_w_q;
      wp_q <= sp_q * s3_w_q;
      wn_q <= sn_q * s3_w_q;
      s4_row_q <= s3_row_q; s4_use_q <= s3_use_q; s4_last_q <= s3_last_q;
    end
  end

  assign fin = s4_v_q && s4_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0; s2_v_q <= 1'b0; s3_v_q <= 1'b0; s4_v_q <= 1'b0; o_v_q <= 1'b0;
      for (int r = 0; r < 4; r++) accp_q[r] <= '0;
      for (int r = 0; r < 3; r++) accn_q[r] <= '0;
    end else begin
      if (adv) begin
        s1_v_q <= issue; s2_v_q <= s1_v_q; s3_v_q <= s2_v_q; s4_v_q <= s3_v_q;
        if (fin) begin
          for (int r = 0; r < 4; r++) accp_q[r] <= '0;
          for (int r = 0; r < 3; r++) accn_q[r] <= '0;
        end else if (s4_v_q && s4_use_q) begin
          accp_q[s4_row_q] <= accp_q[s4_row_q] + AccW'(wp_q >>> 15);
          if (s4_row_q != 2'd3)
            accn_q[s4_row_q] <= accn_q[s4_row_q] + AccW'(wn_q >>> 15);
        end
      end
      if (adv && fin) o_v_q <= 1'b1;
      else if (!out_stall_i) o_v_q <= 1'b0;
    end
  end

  // final row of last influence adds to row 3 only, so x,y,z sums are complete here
  assign fw = (s4_use_q) ? accp_q[3] + AccW'(wp_q >>> 15) : accp_q[3];
  always_ff @(posedge clk_i) begin
    if (adv && fin) begin
      o_q.skinned_x  <= sat32(accp_q[0]);
      o_q.skinned_y  <= sat32(accp_q[1]);
      o_q.skinned_z  <= sat32(accp_q[2]);
      o_q.skinned_w  <= sat32(fw);
      o_q.line_end_x <= sat32(accp_q[0] + (accn_q[0] >>> 1));
      o_q.line_end_y <= sat32(accp_q[1] + (accn_q[1] >>> 1));
      o_q.line_end_z <= sat32(accp_q[2] + (accn_q[2] >>> 1));
    end
  end

  assign out_valid_o = o_v_q;
  assign out_data_o  = o_q;
endmodule

### rtl/linear_blend_vertex_skinning_core.sv
// Top level of the linear blend vertex skinning block.
// Path from an accepted vertex to out_valid_o: queue, job load, 16 row
// fetches (4 influences x 4 rows from the single table port), product, row sum, weight.
// The back end loads the next queued vertex once the current one has issued its 16 row
// fetches; a matrix write waits until queued and running vertices have fetched their rows.
// Reset: clears queue, sequencer and accumulators; the bone table is not cleared.
module linear_blend_vertex_skinning_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lbvs_pkg::req_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lbvs_pkg::req_out_t out_data_o
);
  import lbvs_pkg::*;

  logic               mem_we, job_valid, job_pop, back_busy;
  logic [MemAw-1:0]   mem_waddr;
  logic signed [31:0] mem_wdata;
  job_t               job;

  // front: matrix writes go straight to the table once no vertex is pending,
  // vertices into a 2-deep queue
  lbvs_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .back_busy_i(back_busy),
    .mem_we_o(mem_we), .mem_waddr_o(mem_waddr), .mem_wdata_o(mem_wdata),
    .job_valid_o(job_valid), .job_pop_i(job_pop), .job_o(job)
  );

  // back: row fetch, multiply, weight and accumulate, saturating output register
  lbvs_back u_back (
    .clk_i, .rst_ni,
    .mem_we_i(mem_we), .mem_waddr_i(mem_waddr), .mem_wdata_i(mem_wdata),
    .job_valid_i(job_valid), .job_pop_o(job_pop), .job_i(job),
    .busy_o(back_busy),
    .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule

### sim/tb_linear_blend_vertex_skinning_core.sv
// Self-checking testbench for the linear blend vertex skinning core.
module tb_linear_blend_vertex_skinning_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lbvs_pkg::*;

  localparam bit KindWrite  = 1'b0;
  localparam bit KindVertex = 1'b1;
  localparam int NumRandom  = 1400;
  localparam int MaxReports = 10;

  // One stimulus row; a typed-in expectation overrides the predictor.
  typedef struct {
    req_in_t  req;
    bit       has_exp;
    req_out_t exp;
  } stim_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  req_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  req_out_t out_data_o;

  linear_blend_vertex_skinning_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #4ms;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: private copy of the bone table, updated as requests are accepted.
  // ---------------------------------------------------------------------------
  logic signed [31:0] bone_tbl [MemDepth];
  req_out_t           skin_q [$];
  stim_row_t          stim_q [$];
  int                 mismatches = 0;

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sh7fffffff) return 32'sh7fffffff;
    if (v < -128'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic req_out_t skin_vertex(input req_in_t r);
    logic signed [127:0] pos [4];
    logic signed [127:0] nrm [3];
    logic signed [127:0] acc_p [4];
    logic signed [127:0] acc_n [3];
    logic signed [127:0] sp, sn, w, m;
    logic [6:0]          id;
    logic [15:0]         wraw;
    req_out_t            o;
    pos[0] = r.pos_x; pos[1] = r.pos_y; pos[2] = r.pos_z; pos[3] = 65536;
    nrm[0] = r.norm_x; nrm[1] = r.norm_y; nrm[2] = r.norm_z;
    for (int k = 0; k < 4; k++) acc_p[k] = 0;
    for (int k = 0; k < 3; k++) acc_n[k] = 0;
    for (int i = 0; i < Influences; i++) begin
      id   = r.bone_ids[i*7 +: 7];
      wraw = r.bone_weights[i*16 +: 16];
      w    = $signed(wraw);
      // non-positive weights drop the influence
      if (w <= 0) continue;
      for (int row = 0; row < 4; row++) begin
        sp = 0;
        sn = 0;
        for (int c = 0; c < 4; c++) begin
          m  = bone_tbl[id*16 + row*4 + c];
          sp = sp + ((m * pos[c]) >>> 16);
          if (c < 3) sn = sn + ((m * nrm[c]) >>> 16);
        end
        acc_p[row] = acc_p[row] + ((sp * w) >>> 15);
        if (row < 3) acc_n[row] = acc_n[row] + ((sn * w) >>> 15);
      end
    end
    o.skinned_x  = clamp32(acc_p[0]);
    o.skinned_y  = clamp32(acc_p[1]);
    o.skinned_z  = clamp32(acc_p[2]);
    o.skinned_w  = clamp32(acc_p[3]);
    // line end uses the unclamped position sum
    o.line_end_x = clamp32(acc_p[0] + (acc_n[0] >>> 1));
    o.line_end_y = clamp32(acc_p[1] + (acc_n[1] >>> 1));
    o.line_end_z = clamp32(acc_p[2] + (acc_n[2] >>> 1));
    return o;
  endfunction

  task automatic accept_request(input stim_row_t row);
    if (row.req.kind == KindWrite) begin
      bone_tbl[row.req.bone_slot*16 + row.req.matrix_element] = row.req.matrix_value;
    end else if (row.has_exp) begin
      skin_q.insert(skin_q.size(), row.exp);
    end else begin
      skin_q.insert(skin_q.size(), skin_vertex(row.req));
    end
  endtask

  task automatic add_row(input stim_row_t s);
    stim_q.insert(stim_q.size(), s);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus construction. Written elements are tracked per slot so that a
  // positively weighted influence only ever points at a fully written bone.
  // ---------------------------------------------------------------------------
  logic [15:0] written [MaxBones];
  int          full_slots [$];

  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(3, 0))
      0:       return $urandom;                                   // full range
      1:       return $signed($urandom_range(131072, 0)) - 65536; // near +-1.0
      default: return $signed($urandom_range(1 << 20, 0)) - (1 << 19);
    endcase
  endfunction

  function automatic stim_row_t mk_write(input int slot, input int elem,
                                         input logic signed [31:0] val);
    stim_row_t s;
    s.req                = '0;
    s.req.kind           = KindWrite;
    s.req.bone_slot      = 7'(slot);
    s.req.matrix_element = 4'(elem);
    s.req.matrix_value   = val;
    // unused fields still toggle
    s.req.pos_x          = $urandom;
    s.req.bone_weights   = {$urandom, $urandom};
    s.has_exp            = 1'b0;
    s.exp                = '0;
    return s;
  endfunction

  task automatic note_write(input int slot, input int elem);
    if (written[slot] != 16'hffff) begin
      written[slot][elem] = 1'b1;
      if (written[slot] == 16'hffff) full_slots.insert(full_slots.size(), slot);
    end
  endtask

  function automatic stim_row_t mk_vertex();
    stim_row_t   s;
    logic [15:0] w;
    s.req        = '0;
    s.req.kind   = KindVertex;
    s.req.bone_slot      = 7'($urandom);
    s.req.matrix_element = 4'($urandom);
    s.req.matrix_value   = $urandom;
    s.req.pos_x  = rand_q16();
    s.req.pos_y  = rand_q16();
    s.req.pos_z  = rand_q16();
    s.req.norm_x = rand_q16();
    s.req.norm_y = rand_q16();
    s.req.norm_z = rand_q16();
    for (int i = 0; i < Influences; i++) begin
      case ($urandom_range(5, 0))
        0:       w = 16'h0000;
        1:       w = 16'h8000 | 16'($urandom);  // negative, skipped
        2:       w = 16'h7fff;
        default: w = 16'($urandom_range(16'h7fff, 1));
      endcase
      if (!w[15] && w != 0 && full_slots.size() == 0) w = 16'h0000;
      if (!w[15] && w != 0)
        s.req.bone_ids[i*7 +: 7] =
          7'(full_slots[$urandom_range(full_slots.size()-1, 0)]);
      else
        s.req.bone_ids[i*7 +: 7] = 7'($urandom);
      s.req.bone_weights[i*16 +: 16] = w;
    end
    s.has_exp = 1'b0;
    s.exp     = '0;
    return s;
  endfunction

  task automatic build_stimulus();
    stim_row_t s;
    int        order [16];
    int        slot, tmp, j, n_vtx;
    for (int b = 0; b < MaxBones; b++) written[b] = '0;

    // Directed: no usable influence gives all zeros, even over unwritten bones.
    s = mk_vertex();
    s.req.pos_x = 32'sh7fffffff; s.req.pos_y = 32'sh80000000; s.req.pos_z = 32'sh7fffffff;
    s.req.norm_x = 32'sh80000000; s.req.norm_y = 32'sh7fffffff; s.req.norm_z = 32'sh80000000;
    s.req.bone_ids = '1;
    s.req.bone_weights = '0;
    s.has_exp = 1'b1;
    add_row(s);
    s.req.bone_weights = 64'h8000_ffff_8001_8000;   // all negative
    s.req.bone_ids = '0;
    add_row(s);
    // Top slot filled with alternating extremes, then saturating vertices.
    for (int e = 0; e < 16; e++) begin
      s = mk_write(127, e, e[0] ? 32'sh80000000 : 32'sh7fffffff);
      add_row(s);
      note_write(127, e);
    end
    s = mk_vertex();
    s.req.pos_x = 32'sh7fffffff; s.req.pos_y = 32'sh80000000; s.req.pos_z = 32'sh7fffffff;
    s.req.norm_x = 32'sh7fffffff; s.req.norm_y = 32'sh80000000; s.req.norm_z = 32'sh7fffffff;
    s.req.bone_ids = {4{7'd127}};
    s.req.bone_weights = {4{16'h7fff}};
    add_row(s);
    s.req.pos_x = 32'sh80000000; s.req.pos_y = 32'sh7fffffff; s.req.pos_z = 32'sh80000000;
    s.req.bone_weights = 64'h0000_8000_0000_0001;
    add_row(s);

    // Random: mostly full matrix loads followed by a few vertices, plus stray writes.
    while (stim_q.size() < NumRandom) begin
      if ($urandom_range(9, 0) < 7) begin
        slot = $urandom_range(MaxBones-1, 0);
        for (int e = 0; e < 16; e++) order[e] = e;
        for (int e = 15; e > 0; e--) begin
          j = $urandom_range(e, 0);
          tmp = order[e]; order[e] = order[j]; order[j] = tmp;
        end
        for (int e = 0; e < 16; e++) begin
          add_row(mk_write(slot, order[e], rand_q16()));
          note_write(slot, order[e]);
        end
      end else begin
        slot = $urandom_range(MaxBones-1, 0);
        tmp  = $urandom_range(15, 0);
        add_row(mk_write(slot, tmp, rand_q16()));
        note_write(slot, tmp);
      end
      n_vtx = $urandom_range(8, 1);
      for (int v = 0; v < n_vtx; v++) add_row(mk_vertex());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: bursts of random length separated by random gaps.
  // ---------------------------------------------------------------------------
  int stim_idx  = 0;
  int burst_len = 0;
  int gap_len   = 0;
  bit stim_ready = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) accept_request(stim_q[stim_idx-1]);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_len > 0) begin
          gap_len    <= gap_len - 1;
          in_valid_i <= 1'b0;
        end else if (stim_ready && stim_idx < stim_q.size()) begin
          in_valid_i <= 1'b1;
          in_data_i  <= stim_q[stim_idx].req;
          stim_idx   <= stim_idx + 1;
          if (burst_len == 0) begin
            burst_len <= $urandom_range(24, 1);
            // a third of bursts run back to back with no gap
            gap_len   <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 1);
          end else begin
            burst_len <= burst_len - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: stall pattern switches mode every so often.
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left  = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(3, 0);
        mode_left  <= $urandom_range(300, 20);
      end else begin
        mode_left  <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(3, 0) == 0);
        2:       out_stall_i <= ($urandom_range(3, 0) != 0);
        default: out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  // Checker: each accepted result against the oldest expectation.
  logic [6:0][31:0] got_f, exp_f;
  string field_name [7] = '{"line_end_z", "line_end_y", "line_end_x", "skinned_w",
                            "skinned_z", "skinned_y", "skinned_x"};

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (skin_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result %h", out_data_o);
      end else begin
        exp_f = skin_q.pop_front();
        got_f = out_data_o;
        for (int f = 0; f < 7; f++) begin
          if (got_f[f] !== exp_f[f]) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("%s mismatch: expected %h, got %h", field_name[f], exp_f[f],
                       got_f[f]);
          end
        end
      end
    end
  end

  initial begin
    build_stimulus();
    stim_ready = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_idx == stim_q.size() && !in_valid_i);
    wait (skin_q.size() == 0);
    // idle time after the last result, so that any unexpected extra result is caught
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && skin_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/lbvs_pkg.sv
rtl/lbvs_front.sv
rtl/lbvs_back.sv
rtl/linear_blend_vertex_skinning_core.sv
sim/tb_linear_blend_vertex_skinning_core.sv
